>>> hw/rtl/fpts_pkg.sv
// Shared types, constants and helper functions for the flyback pulse timing block.
package fpts_pkg;

   // Port widths
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Field widths
   localparam int SUPPLY_W = 16;
   localparam int VOUT_W   = 10;
   localparam int TIME_W   = 32;
   localparam int IND_W    = 32;
   localparam int FAULT_W  = 3;
   localparam int ON_CY_W  = 5;
   localparam int OFF_CY_W = 7;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_VIN_MIN     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIN_MAX     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REDUCED     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDUCTANCE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEADLINE    = 3'd5;

   // Configuration reset values
   localparam logic [SUPPLY_W-1:0] VIN_MIN_RESET    = 16'd4000;
   localparam logic [SUPPLY_W-1:0] VIN_MAX_RESET    = 16'd12000;
   localparam logic [SUPPLY_W-1:0] REDUCED_RESET    = 16'd5500;
   localparam logic [IND_W-1:0]    INDUCTANCE_RESET = 32'd10000000;
   localparam logic [VOUT_W-1:0]   TARGET_RESET     = 10'd475;
   localparam logic [TIME_W-1:0]   DEADLINE_RESET   = 32'hFFFF_FFFF;

   // Fault bit positions
   localparam int FAULT_LOW     = 0;
   localparam int FAULT_HIGH    = 1;
   localparam int FAULT_TIMEOUT = 2;

   // Timing constants in nanoseconds or picohenries, with a supply offset in millivolts, a scale and cycle limits
   localparam int SUPPLY_OFFSET_MV = 500;
   localparam int REDUCED_IND_PH   = 3000000;
   localparam int ON_OFFSET_NS     = 42;
   localparam int CYCLE_NS         = 104;
   localparam int OFF_SCALE        = 50;
   localparam int OFF_BASE_NS      = 1000;
   localparam int OFF_OFFSET_NS    = 250;
   localparam int OFF_MAX_CY       = 120;
   localparam int ON_MAX_CY        = 29;

   // A burst fires when the on count lies in 1..29, which is this on_ns window.
   localparam int ON_NS_MIN   = ON_OFFSET_NS + CYCLE_NS;
   localparam int ON_NS_LIMIT = ON_OFFSET_NS + (ON_MAX_CY + 1) * CYCLE_NS;

   // The off time is always at least 1000 ns, so the short-off case never applies.
   // Off cycles are (q * 50 + 750) / 104; any quotient above this one clamps to 120.
   localparam int OFF_BIAS_NS   = OFF_BASE_NS - OFF_OFFSET_NS;
   localparam int OFF_CLAMP_QUO =
      ((OFF_MAX_CY + 1) * CYCLE_NS - OFF_BIAS_NS - 1) / OFF_SCALE;

   // Division by 104 through a reciprocal, exact for 14 bit operands.
   localparam int RECIP_SHIFT = 21;
   localparam int RECIP_104   = (1 << RECIP_SHIFT) / CYCLE_NS + 1;
   localparam int SMALL_W     = 14;
   localparam int PROD_W      = 29;

   // Serial divider size
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int DIVISOR_W = 16;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_PROGRESS = 2'd0,
      STATUS_DONE     = 2'd1,
      STATUS_FAIL     = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic start_div1;
      logic save_on;
      logic start_div2;
      logic save_off;
      logic load_out;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic skip;
      logic div_busy;
      logic div_done;
      logic out_free;
   } dp_stat_type;

   // Floor of x / 104 kept to 7 bits; exact for any 14 bit x below 13312, where the result fits.
   function automatic logic [OFF_CY_W-1:0] div104(input logic [SMALL_W-1:0] x);
      logic [PROD_W-1:0] p;
      p = PROD_W'(x) * PROD_W'(RECIP_104);
      return p[RECIP_SHIFT+OFF_CY_W-1:RECIP_SHIFT];
   endfunction

endpackage

>>> hw/rtl/fpts_div.sv
// Restoring serial divider: 32 bit dividend, 16 bit divisor, one quotient bit a cycle.
module fpts_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fpts_pkg::DIV_STEPS-1:0]  dividend,
   input  logic [fpts_pkg::DIVISOR_W-1:0]  divisor,
   output logic                            busy,
   output logic                            done,
   output logic [fpts_pkg::DIV_STEPS-1:0]  quotient
);
   import fpts_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIV_STEPS-1:0]  quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    rem_diff;
   logic                  fits;

   // One trial subtraction per cycle.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIV_STEPS-1]};
      rem_diff  = rem_shift - {1'b0, dsr_ff};
      fits      = rem_shift >= {1'b0, dsr_ff};
   end

   // Next-state logic for the iteration.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[DIV_STEPS-2:0], fits};
         rem_in   = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hw/rtl/fpts_datapath.sv
// Datapath: configuration registers, sticky faults, timing arithmetic and the output register.
module fpts_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [fpts_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fpts_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [fpts_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  fpts_pkg::dp_cmd_type              cmd,
   output fpts_pkg::dp_stat_type             stat,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fpts_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import fpts_pkg::*;

   // Configuration registers
   logic [SUPPLY_W-1:0] vin_min_ff, vin_max_ff, reduced_ff;
   logic [IND_W-1:0]    ind_ff;
   logic [VOUT_W-1:0]   target_ff;
   logic [TIME_W-1:0]   deadline_ff;

   // Sample and working registers
   logic [FAULT_W-1:0]  faults_ff, faults_in;
   logic [SUPPLY_W-1:0] supply_ff;
   logic [VOUT_W-1:0]   vout_ff;
   logic [DIV_STEPS-1:0] on_ns_ff;
   logic                off_clamp_ff;
   logic [SMALL_W-1:0]  off_x_ff;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [SUPPLY_W-1:0] req_supply;
   logic [VOUT_W-1:0]   req_vout;
   logic [TIME_W-1:0]   req_time;

   logic [IND_W-1:0]     ind_eff;
   logic                 div_start;
   logic [DIV_STEPS-1:0] div_dividend;
   logic [DIVISOR_W-1:0] div_divisor;
   logic                 div_busy, div_done;
   logic [DIV_STEPS-1:0] div_quotient;

   logic                 failure, fire;
   logic [SMALL_W-1:0]   on_d;
   logic [OFF_CY_W-1:0]  on_full, off_full;
   logic [ON_CY_W-1:0]   on_cy;
   logic [OFF_CY_W-1:0]  off_cy;
   status_type           status;

   // Unpack the request word.
   assign req_supply = req_tdata[SUPPLY_W-1:0];
   assign req_vout   = req_tdata[SUPPLY_W+VOUT_W-1:SUPPLY_W];
   assign req_time   = req_tdata[SUPPLY_W+VOUT_W+TIME_W-1:SUPPLY_W+VOUT_W];

   // Configuration writes; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         vin_min_ff  <= VIN_MIN_RESET;
         vin_max_ff  <= VIN_MAX_RESET;
         reduced_ff  <= REDUCED_RESET;
         ind_ff      <= INDUCTANCE_RESET;
         target_ff   <= TARGET_RESET;
         deadline_ff <= DEADLINE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VIN_MIN:    vin_min_ff  <= csr_wdata[SUPPLY_W-1:0];
            CSR_VIN_MAX:    vin_max_ff  <= csr_wdata[SUPPLY_W-1:0];
            CSR_REDUCED:    reduced_ff  <= csr_wdata[SUPPLY_W-1:0];
            CSR_INDUCTANCE: ind_ff      <= csr_wdata[IND_W-1:0];
            CSR_TARGET:     target_ff   <= csr_wdata[VOUT_W-1:0];
            CSR_DEADLINE:   deadline_ff <= csr_wdata[TIME_W-1:0];
            default:        ;
         endcase
      end
   end

   // Sticky fault flags gather each new word's checks.
   always_comb begin
      faults_in = faults_ff;
      if (cmd.capture) begin
         faults_in[FAULT_LOW]     = faults_ff[FAULT_LOW] | (req_supply < vin_min_ff);
         faults_in[FAULT_HIGH]    = faults_ff[FAULT_HIGH] | (req_supply > vin_max_ff);
         faults_in[FAULT_TIMEOUT] = faults_ff[FAULT_TIMEOUT] | (req_time > deadline_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         faults_ff <= '0;
      end else begin
         faults_ff <= faults_in;
      end
   end

   // Reduced-current mode lowers the inductance term, saturating at zero.
   always_comb begin
      ind_eff = ind_ff;
      if (supply_ff < reduced_ff) begin
         ind_eff = (ind_ff > IND_W'(REDUCED_IND_PH)) ? ind_ff - IND_W'(REDUCED_IND_PH) : '0;
      end
   end

   // The divider first gives on_ns, then on_ns over (out_volts + 1).
   assign div_start    = cmd.start_div1 | cmd.start_div2;
   assign div_dividend = cmd.start_div1 ? ind_eff : on_ns_ff;
   assign div_divisor  = cmd.start_div1 ? (supply_ff - DIVISOR_W'(SUPPLY_OFFSET_MV))
                                        : DIVISOR_W'({1'b0, vout_ff} + 11'd1);

   fpts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Sample capture and the two saved quotients. A skipped word keeps on_ns at zero.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         supply_ff <= req_supply;
         vout_ff   <= req_vout;
         on_ns_ff  <= '0;
      end
      if (cmd.save_on) begin
         on_ns_ff <= div_quotient;
      end
      if (cmd.save_off) begin
         off_clamp_ff <= div_quotient > DIV_STEPS'(OFF_CLAMP_QUO);
         off_x_ff     <= SMALL_W'({6'b0, div_quotient[7:0]} * SMALL_W'(OFF_SCALE))
                         + SMALL_W'(OFF_BIAS_NS);
      end
   end

   // Result fields from the saved values.
   always_comb begin
      failure  = faults_ff != '0;
      fire     = !failure && (on_ns_ff >= DIV_STEPS'(ON_NS_MIN))
                 && (on_ns_ff < DIV_STEPS'(ON_NS_LIMIT));
      on_d     = on_ns_ff[SMALL_W-1:0] - SMALL_W'(ON_OFFSET_NS);
      on_full  = div104(on_d);
      off_full = off_clamp_ff ? OFF_CY_W'(OFF_MAX_CY) : div104(off_x_ff);
      on_cy    = fire ? on_full[ON_CY_W-1:0] : '0;
      off_cy   = fire ? off_full : '0;
      if (failure) begin
         status = STATUS_FAIL;
      end else if (vout_ff >= target_ff) begin
         status = STATUS_DONE;
      end else begin
         status = STATUS_PROGRESS;
      end
      rsp_data_in = RSP_DATA_W'({faults_ff, off_cy, on_cy, fire, status});
   end

   // Output register holds a word until the sink takes it.
   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in  = cmd.load_out | (rsp_valid_ff & !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Status toward the controller.
   assign stat.skip     = (faults_ff != '0) || (supply_ff <= SUPPLY_W'(SUPPLY_OFFSET_MV));
   assign stat.div_busy = div_busy;
   assign stat.div_done = div_done;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hw/rtl/fpts_ctrl.sv
// Controller: sequences capture, the two divider passes and the result load.
module fpts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  fpts_pkg::dp_stat_type  stat,
   output fpts_pkg::dp_cmd_type   cmd
);
   import fpts_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_EVAL   = 6'b000010,
      ST_DIV1   = 6'b000100,
      ST_MID    = 6'b001000,
      ST_DIV2   = 6'b010000,
      ST_RESULT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            // Faults or a supply too low for timing go straight to the result.
            if (stat.skip) begin
               state_in = ST_RESULT;
            end else begin
               cmd.start_div1 = 1'b1;
               state_in       = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (stat.div_done) begin
               cmd.save_on = 1'b1;
               state_in    = ST_MID;
            end
         end
         ST_MID: begin
            cmd.start_div2 = 1'b1;
            state_in       = ST_DIV2;
         end
         ST_DIV2: begin
            if (stat.div_done) begin
               cmd.save_off = 1'b1;
               state_in     = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;

endmodule

>>> hw/rtl/flyback_pulse_timing_step_top.sv
// Top level of the flyback pulse timing block: controller, datapath and checks.
// A word with a fault or a supply at or below 500 mV passes from acceptance through the
// evaluation state to the result; any other word first makes two 32-step passes
// through the shared serial divider. A new word is taken only once the last result is
// in the output register. Reset is synchronous and active high: it restores the
// configuration defaults, clears the sticky faults and empties the output register.
module flyback_pulse_timing_step_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [fpts_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fpts_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_tdata from bit 0: supply_mv[15:0], out_volts[25:16], now_time[57:26], zero pad
   input  logic [fpts_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata from bit 0: status[1:0], fire_burst[2], on_cycles[7:3], off_cycles[14:8],
   // fault_bits[17:15], zero pad
   output logic [fpts_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import fpts_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   fpts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fpts_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Only one word is in work: after an accept the input side closes.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while a word is in work");

   // The result is loaded only when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> stat.out_free)
      else $error("result loaded over a pending word");

   // The divider is never restarted in the middle of a pass.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.start_div1 || cmd.start_div2) |-> !stat.div_busy)
      else $error("divider started while busy");

   // Any fault bit means failure with no burst.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[17:15] != 3'd0)) |->
         (rsp_tdata[1:0] == STATUS_FAIL) && !rsp_tdata[2])
      else $error("fault reported without failure status");

endmodule

>>> verif/flyback_pulse_timing_checker.sv
// Checker for the flyback pulse timing block: tracks settings, predicts each result word and compares.
module flyback_pulse_timing_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [fpts_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fpts_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // req_tdata from bit 0: supply_mv[15:0], out_volts[25:16], now_time[57:26], zero pad
   input  logic [fpts_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata from bit 0: status[1:0], fire_burst[2], on_cycles[7:3], off_cycles[14:8],
   // fault_bits[17:15], zero pad
   input  logic [fpts_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output int                                mismatches,
   output int                                pending,
   output int                                results_checked,
   output int                                bursts_seen,
   output int                                failures_seen
);

   localparam int REPORT_LIMIT = 10;

   // One expected result word, split into its fields.
   typedef struct packed {
      fpts_pkg::status_type status;
      logic                 fire;
      logic [4:0]           on_cy;
      logic [6:0]           off_cy;
      logic [2:0]           faults;
   } pulse_timing_type;

   // Local copy of the settings and of the sticky faults.
   logic [15:0] cfg_vin_min;
   logic [15:0] cfg_vin_max;
   logic [15:0] cfg_reduced;
   logic [31:0] cfg_inductance;
   logic [9:0]  cfg_target;
   logic [31:0] cfg_deadline;
   logic [2:0]  sticky_faults;

   pulse_timing_type pulse_timing_q[$];

   // Works out the result of one sample from the settings and the faults seen so far.
   function automatic pulse_timing_type predict_timing(input logic [15:0] supply,
                                                       input logic [9:0]  vout,
                                                       input logic [31:0] now_t,
                                                       input logic [2:0]  faults_in);
      pulse_timing_type r;
      logic [2:0]    f;
      logic [63:0]   ind;
      logic [63:0]   on_ns;
      logic [63:0]   off_ns;
      logic [63:0]   on_c;
      logic [63:0]   off_c;
      f = faults_in;
      if (supply < cfg_vin_min) f[0] = 1'b1;
      if (supply > cfg_vin_max) f[1] = 1'b1;
      if (now_t > cfg_deadline) f[2] = 1'b1;
      r.faults = f;
      r.status = fpts_pkg::STATUS_FAIL;
      r.fire   = 1'b0;
      r.on_cy  = '0;
      r.off_cy = '0;
      if (f == 3'd0) begin
         // On time: inductance over the supply headroom, reduced current below threshold.
         on_ns = 64'd0;
         if (supply > 16'd500) begin
            ind = {32'd0, cfg_inductance};
            if (supply < cfg_reduced)
               ind = (ind > 64'd3000000) ? ind - 64'd3000000 : 64'd0;
            on_ns = ind / ({48'd0, supply} - 64'd500);
         end
         off_ns = (on_ns / ({54'd0, vout} + 64'd1)) * 64'd50 + 64'd1000;
         on_c   = (on_ns >= 64'd42) ? (on_ns - 64'd42) / 64'd104 : 64'd0;
         off_c  = (off_ns > 64'd360) ? (off_ns - 64'd250) / 64'd104 : 64'd1;
         if (off_c > 64'd120) off_c = 64'd120;
         r.fire   = (on_c > 64'd0) && (on_c < 64'd30);
         r.status = (vout >= cfg_target) ? fpts_pkg::STATUS_DONE : fpts_pkg::STATUS_PROGRESS;
         if (r.fire) begin
            r.on_cy  = on_c[4:0];
            r.off_cy = off_c[6:0];
         end
      end
      return r;
   endfunction

   // Watch the three ports at each rising edge.
   always @(posedge clock) begin : watch
      pulse_timing_type want;
      if (reset) begin
         cfg_vin_min    = fpts_pkg::VIN_MIN_RESET;
         cfg_vin_max    = fpts_pkg::VIN_MAX_RESET;
         cfg_reduced    = fpts_pkg::REDUCED_RESET;
         cfg_inductance = fpts_pkg::INDUCTANCE_RESET;
         cfg_target     = fpts_pkg::TARGET_RESET;
         cfg_deadline   = fpts_pkg::DEADLINE_RESET;
         sticky_faults  = 3'd0;
         pulse_timing_q.delete();
         pending = 0;
      end else begin
         // Register writes.
         if (csr_we) begin
            case (csr_index)
               fpts_pkg::CSR_VIN_MIN:    cfg_vin_min    = csr_wdata[15:0];
               fpts_pkg::CSR_VIN_MAX:    cfg_vin_max    = csr_wdata[15:0];
               fpts_pkg::CSR_REDUCED:    cfg_reduced    = csr_wdata[15:0];
               fpts_pkg::CSR_INDUCTANCE: cfg_inductance = csr_wdata;
               fpts_pkg::CSR_TARGET:     cfg_target     = csr_wdata[9:0];
               fpts_pkg::CSR_DEADLINE:   cfg_deadline   = csr_wdata;
               default: ;
            endcase
         end

         // Result words are compared with the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            if (pulse_timing_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("Result word %h arrived with no sample outstanding", rsp_tdata);
            end else begin
               want = pulse_timing_q.pop_front();
               results_checked++;
               if (want.fire) bursts_seen++;
               if (want.status == fpts_pkg::STATUS_FAIL) failures_seen++;
               if (rsp_tdata[1:0] !== want.status || rsp_tdata[2] !== want.fire ||
                   rsp_tdata[7:3] !== want.on_cy || rsp_tdata[14:8] !== want.off_cy ||
                   rsp_tdata[17:15] !== want.faults) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("Result %0d: expected status %0d burst %0b on %0d off %0d faults %b",
                              results_checked, want.status, want.fire, want.on_cy,
                              want.off_cy, want.faults);
                     $display("   got status %0d burst %0b on %0d off %0d faults %b",
                              rsp_tdata[1:0], rsp_tdata[2], rsp_tdata[7:3], rsp_tdata[14:8],
                              rsp_tdata[17:15]);
                  end
               end
            end
         end

         // Accepted samples get their prediction queued.
         if (req_tvalid && req_tready) begin
            want = predict_timing(req_tdata[15:0], req_tdata[25:16], req_tdata[57:26],
                                  sticky_faults);
            sticky_faults = want.faults;
            pulse_timing_q.push_back(want);
         end
         pending = pulse_timing_q.size();
      end
   end

endmodule

>>> verif/testbench.sv
// Top of the flyback pulse timing testbench: clock, reset, stimulus and verdict.
module testbench;

   import fpts_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 210;
   localparam int TAIL_ITEMS    = 25;
   localparam int DRAIN_CYCLES  = 100;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   // req_tdata from bit 0: supply_mv[15:0], out_volts[25:16], now_time[57:26], zero pad
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // rsp_tdata from bit 0: status[1:0], fire_burst[2], on_cycles[7:3], off_cycles[14:8],
   // fault_bits[17:15], zero pad
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   // Idle percentages of the sender and the receiver.
   int tx_idle_pct = 21;
   int rx_idle_pct = 79;

   // Settings currently programmed, used to keep samples inside the limits.
   logic [15:0] cfg_vin_min;
   logic [15:0] cfg_vin_max;
   logic [15:0] cfg_reduced;
   logic [31:0] cfg_inductance;
   logic [9:0]  cfg_target;
   logic [31:0] cfg_deadline;

   int cycle_count = 0;
   int samples_sent = 0;
   int settings_used = 1;
   int mismatches;
   int pending;
   int results_checked;
   int bursts_seen;
   int failures_seen;

   flyback_pulse_timing_step_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   flyback_pulse_timing_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatches      (mismatches),
      .pending         (pending),
      .results_checked (results_checked),
      .bursts_seen     (bursts_seen),
      .failures_seen   (failures_seen)
   );

   always #10 clock = ~clock;

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results outstanding",
                  cycle_count, pending);
         $display("[flyback_pulse_timing_step_top] ERROR");
         $finish;
      end
   end

   // Drop valid and wait until every sent sample has its result back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   // Program all six registers; the block must be idle.
   task automatic write_settings(input logic [15:0] vmin, input logic [15:0] vmax,
                                 input logic [15:0] red, input logic [31:0] ind,
                                 input logic [9:0] tgt, input logic [31:0] dl);
      wait_idle();
      cfg_vin_min    = vmin;
      cfg_vin_max    = vmax;
      cfg_reduced    = red;
      cfg_inductance = ind;
      cfg_target     = tgt;
      cfg_deadline   = dl;
      csr_we    <= 1'b1;
      csr_index <= CSR_VIN_MIN;
      csr_wdata <= {16'd0, vmin};
      @(posedge clock);
      csr_index <= CSR_VIN_MAX;
      csr_wdata <= {16'd0, vmax};
      @(posedge clock);
      csr_index <= CSR_REDUCED;
      csr_wdata <= {16'd0, red};
      @(posedge clock);
      csr_index <= CSR_INDUCTANCE;
      csr_wdata <= ind;
      @(posedge clock);
      csr_index <= CSR_TARGET;
      csr_wdata <= {22'd0, tgt};
      @(posedge clock);
      csr_index <= CSR_DEADLINE;
      csr_wdata <= dl;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Present one sample word, with an optional idle gap before it.
   task automatic send_sample(input logic [15:0] supply, input logic [9:0] vout,
                              input logic [31:0] now_t);
      int gap;
      gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(90, 1) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, now_t, vout, supply};
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   // Settings for one random phase; the first two pin several extremes.
   task automatic random_settings(input int phase);
      logic [15:0] vmin;
      logic [15:0] vmax;
      logic [15:0] red;
      logic [31:0] ind;
      logic [9:0]  tgt;
      logic [31:0] dl;
      vmin = 16'($urandom_range(5000, 501));
      vmax = 16'($urandom_range(65535, vmin));
      red  = 16'($urandom_range(20000, 0));
      tgt  = 10'($urandom_range(1023, 0));
      dl   = $urandom_range(32'hFFFF_FFFF, 5000);
      case ($urandom_range(3))
         0:       ind = 32'd3000000;
         1:       ind = $urandom_range(32'hFFFF_FFFF, 3000000);
         default: ind = $urandom_range(50000000, 3000000);
      endcase
      if (phase == 0) begin
         vmin = 16'd501;
         vmax = 16'hFFFF;
         red  = 16'd0;
         ind  = $urandom_range(40000000, 3000000);
         dl   = 32'hFFFF_FFFF;
      end else if (phase == 1) begin
         vmax = 16'hFFFF;
         red  = 16'hFFFF;
         ind  = $urandom_range(23000000, 3000000);
         tgt  = 10'd1023;
         dl   = 32'hFFFF_FFFF;
      end
      write_settings(vmin, vmax, red, ind, tgt, dl);
   endtask

   // A sample inside the current limits, biased toward the thresholds.
   task automatic random_sample();
      logic [15:0] s;
      logic [9:0]  v;
      logic [31:0] t;
      case ($urandom_range(9))
         0:       s = cfg_vin_min;
         1:       s = cfg_vin_max;
         2:       s = (cfg_reduced >= cfg_vin_min && cfg_reduced <= cfg_vin_max) ?
                      cfg_reduced : cfg_vin_min;
         3:       s = (cfg_reduced > cfg_vin_min && cfg_reduced <= cfg_vin_max) ?
                      cfg_reduced - 16'd1 : cfg_vin_max;
         default: s = 16'($urandom_range(cfg_vin_max, cfg_vin_min));
      endcase
      case ($urandom_range(19))
         0:       v = cfg_target;
         1:       v = cfg_target - 10'd1;
         2:       v = 10'd0;
         default: v = 10'($urandom_range(1023, 0));
      endcase
      t = ($urandom_range(9) == 0) ? cfg_deadline : $urandom_range(cfg_deadline, 0);
      send_sample(s, v, t);
   endtask

   initial begin
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_index  <= CSR_VIN_MIN;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      cfg_vin_min    = VIN_MIN_RESET;
      cfg_vin_max    = VIN_MAX_RESET;
      cfg_reduced    = REDUCED_RESET;
      cfg_inductance = INDUCTANCE_RESET;
      cfg_target     = TARGET_RESET;
      cfg_deadline   = DEADLINE_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, supply limits, threshold edges and target edges.
      send_sample(16'd4000, 10'd0, 32'd0);
      send_sample(16'd12000, 10'd1023, 32'hFFFF_FFFF);
      send_sample(16'd5499, 10'd474, 32'd123);
      send_sample(16'd5500, 10'd475, 32'd1000);
      send_sample(16'd8000, 10'd476, 32'd5);

      // Smallest inductance: reduced mode leaves no current, so no burst.
      write_settings(16'd501, 16'hFFFF, 16'hFFFF, 32'd3000000, 10'd0, 32'hFFFF_FFFF);
      send_sample(16'd501, 10'd0, 32'd0);
      send_sample(16'hFFFF, 10'd1023, 32'hFFFF_FFFF);
      send_sample(16'hFFFE, 10'd0, 32'd7);

      // Edges of the burst window, with and without a clamped off count.
      write_settings(16'd501, 16'hFFFF, 16'd0, 32'd3000000, 10'd1023, 32'hFFFF_FFFF);
      send_sample(16'd1449, 10'd0, 32'd9);
      send_sample(16'd1448, 10'd0, 32'd10);
      send_sample(16'hFFFF, 10'd1023, 32'd11);
      send_sample(16'd20000, 10'd1023, 32'd12);
      send_sample(16'd21047, 10'd0, 32'd13);
      send_sample(16'd21048, 10'd1, 32'd14);
      send_sample(16'd62000, 10'd5, 32'd15);

      // Largest inductance with a zero deadline: huge on time, off count clamps.
      write_settings(16'd501, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 10'd1023, 32'd0);
      send_sample(16'd501, 10'd1023, 32'd0);
      send_sample(16'hFFFF, 10'd0, 32'd0);

      // Short on time below 42 ns, and a time stamp exactly at the deadline.
      write_settings(16'd501, 16'hFFFF, 16'hFFFF, 32'd3040000, 10'd512, 32'd1000);
      send_sample(16'd1500, 10'd511, 32'd1000);
      send_sample(16'd1453, 10'd512, 32'd999);
      send_sample(16'd1452, 10'd0, 32'd0);

      // Random phases under the three idle patterns.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < 2) begin
            tx_idle_pct = 21;
            rx_idle_pct = 79;
         end else if (phase < 4) begin
            tx_idle_pct = 79;
            rx_idle_pct = 21;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         random_settings(phase);
         repeat (PHASE_ITEMS) random_sample();
      end

      // Faults last, since they stick until reset: high, low, then timeout.
      write_settings(16'd6000, 16'd8000, 16'd5500, 32'd10000000, 10'd475, 32'd1000);
      send_sample(16'd7000, 10'd100, 32'd1000);
      send_sample(16'd8001, 10'd500, 32'd0);
      send_sample(16'd7000, 10'd500, 32'd0);
      send_sample(16'd5999, 10'd0, 32'd0);
      send_sample(16'd7000, 10'd0, 32'd1001);
      write_settings(16'hFFFF, 16'd0, 16'd0, 32'd3000000, 10'd0, 32'd0);
      repeat (TAIL_ITEMS)
         send_sample(16'($urandom_range(65535, 0)), 10'($urandom_range(1023, 0)), $urandom);

      // Drain and report.
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d samples under %0d register settings and three idle patterns.",
               samples_sent, settings_used);
      $display("Checked %0d results: %0d bursts, %0d failures, %0d mismatches.",
               results_checked, bursts_seen, failures_seen, mismatches);
      if (mismatches == 0 && pending == 0)
         $display("[flyback_pulse_timing_step_top] OK");
      else
         $display("[flyback_pulse_timing_step_top] ERROR");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/fpts_pkg.sv
hw/rtl/fpts_div.sv
hw/rtl/fpts_datapath.sv
hw/rtl/fpts_ctrl.sv
hw/rtl/flyback_pulse_timing_step_top.sv
verif/flyback_pulse_timing_checker.sv
verif/testbench.sv
